FILE: src/tmae_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-mode to ANSI encoder package
// Shared item types, the command word passed from front end to back end,
// byte constants and the color code tables.
// ----------------------------------------------------------------------------
package tmae_pkg;

  // Input item: one text-mode cell.
  typedef struct packed {
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic       start_of_screen;
  } in_item_t;

  // Output item: one byte of the ANSI stream.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_cell;
  } out_item_t;

  // Classified cell, as the back end needs it to emit bytes.
  typedef struct packed {
    logic       fg_en;
    logic [3:0] fg_tens;
    logic [3:0] fg_ones;
    logic       bg_en;
    logic [3:0] bg_ones;
    logic [7:0] ch;
    logic       line_end;
  } cmd_t;

  // Depth of the command queue between front end and back end.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] LINE_WIDTH_RESET = 8'd80;

  // Stream bytes.
  localparam logic [7:0] ESC_BYTE  = 8'h1B;
  localparam logic [7:0] LB_BYTE   = 8'h5B;  // '['
  localparam logic [7:0] M_BYTE    = 8'h6D;  // 'm'
  localparam logic [7:0] ZERO_BYTE = 8'h30;  // '0'
  localparam logic [7:0] NL_BYTE   = 8'h0A;

  // ASCII digits are 0x30 plus the digit value.
  localparam logic [3:0] DIGIT_HI = 4'h3;

  // Tens digits of the SGR codes.
  localparam logic [3:0] FG_TENS_NORMAL = 4'd3;
  localparam logic [3:0] FG_TENS_BRIGHT = 4'd9;
  localparam logic [3:0] BG_TENS        = 4'd4;

  // Ones digit of the SGR code for the low three bits of a color index.
  localparam logic [3:0] COLOR_ONES [0:7] = '{
    4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7
  };

endpackage

FILE: src/tmae_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-mode to ANSI encoder front end
// Accepts cells, tracks column and remembered colors, and pushes one
// classified command per cell into the queue.
// ----------------------------------------------------------------------------
module tmae_front
  import tmae_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_write,
  input  logic [7:0] cfg_data,
  input  logic     in_valid,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic [7:0] line_width;
  logic       fg_known;
  logic [3:0] last_fg;
  logic       bg_known;
  logic [2:0] last_bg;
  logic [7:0] column;

  logic [3:0] fg;
  logic [2:0] bg;
  logic [7:0] col_eff;
  logic [7:0] next_col;
  logic       line_end;

  // Decode the cell against the tracked state.
  always_comb begin
    fg       = in_item.attribute[3:0];
    bg       = in_item.attribute[6:4];
    col_eff  = in_item.start_of_screen ? 8'd0 : column;
    next_col = col_eff + 8'd1;
    line_end = (next_col == line_width);

    q_cmd.fg_en    = in_item.start_of_screen || !fg_known || (fg != last_fg);
    q_cmd.fg_tens  = fg[3] ? FG_TENS_BRIGHT : FG_TENS_NORMAL;
    q_cmd.fg_ones  = COLOR_ONES[fg[2:0]];
    q_cmd.bg_en    = in_item.start_of_screen || !bg_known || (bg != last_bg);
    q_cmd.bg_ones  = COLOR_ONES[bg];
    q_cmd.ch       = in_item.char_code;
    q_cmd.line_end = line_end;
  end

  assign q_push = in_valid && !q_full;

  // Tracking state and the line width register.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
      fg_known   <= 1'b0;
      last_fg    <= 4'd0;
      bg_known   <= 1'b0;
      last_bg    <= 3'd0;
      column     <= 8'd0;
    end else begin
      if (cfg_write) begin
        line_width <= cfg_data;
      end
      if (q_push) begin
        last_fg  <= fg;
        last_bg  <= bg;
        fg_known <= !line_end;
        bg_known <= !line_end;
        column   <= line_end ? 8'd0 : next_col;
      end
    end
  end

`ifndef SYNTHESIS
  // A cell that ends a line leaves the column at zero and no color known.
  assert property (@(posedge clk) disable iff (rst)
    q_push && q_cmd.line_end |=> column == 8'd0 && !fg_known && !bg_known)
    else $error("line end did not clear column and colors");
`endif

endmodule

FILE: src/tmae_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-mode to ANSI encoder command queue
// Short register queue of classified cells between front end and back end.
// ----------------------------------------------------------------------------
module tmae_queue
  import tmae_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic nonempty,
  output cmd_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_FULL);
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  // Neither side may overrun or underrun the queue.
  assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && !nonempty))
    else $error("queue overrun or underrun");
`endif

endmodule

FILE: src/tmae_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-mode to ANSI encoder back end
// Steps through a command's bytes into an output register, one byte per cycle
// while not stalled, and loads the next command as the last byte goes out.
// ----------------------------------------------------------------------------
module tmae_back
  import tmae_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_nonempty,
  input  cmd_t      q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // Byte positions within one cell's output.
  typedef enum logic [3:0] {
    S_FG_ESC, S_FG_LB, S_FG_TENS, S_FG_ONES, S_FG_M,
    S_BG_ESC, S_BG_LB, S_BG_TENS, S_BG_ONES, S_BG_M,
    S_CHAR,
    S_RS_ESC, S_RS_LB, S_RS_ZERO, S_RS_M, S_RS_NL
  } step_t;

  logic  busy;
  step_t step;
  cmd_t  cmd;

  logic [7:0] cur_byte;
  logic       is_last;
  step_t      step_after;
  step_t      first_step;
  logic       out_free;
  logic       emit;
  logic       need_cmd;

  // Byte for the current position.
  always_comb begin
    case (step)
      S_FG_ESC, S_BG_ESC, S_RS_ESC: cur_byte = ESC_BYTE;
      S_FG_LB, S_BG_LB, S_RS_LB:    cur_byte = LB_BYTE;
      S_FG_M, S_BG_M, S_RS_M:       cur_byte = M_BYTE;
      S_FG_TENS:                    cur_byte = {DIGIT_HI, cmd.fg_tens};
      S_FG_ONES:                    cur_byte = {DIGIT_HI, cmd.fg_ones};
      S_BG_TENS:                    cur_byte = {DIGIT_HI, BG_TENS};
      S_BG_ONES:                    cur_byte = {DIGIT_HI, cmd.bg_ones};
      S_CHAR:                       cur_byte = cmd.ch;
      S_RS_ZERO:                    cur_byte = ZERO_BYTE;
      S_RS_NL:                      cur_byte = NL_BYTE;
      default:                      cur_byte = cmd.ch;
    endcase
  end

  // Sequencing: skip each color escape whose color is unchanged, stop after the
  // character unless the line ends.
  always_comb begin
    is_last = ((step == S_CHAR) && !cmd.line_end) || (step == S_RS_NL);
    if (step == S_FG_M) begin
      step_after = cmd.bg_en ? S_BG_ESC : S_CHAR;
    end else begin
      step_after = step_t'(4'(step + 4'd1));
    end
    if (q_head.fg_en) begin
      first_step = S_FG_ESC;
    end else if (q_head.bg_en) begin
      first_step = S_BG_ESC;
    end else begin
      first_step = S_CHAR;
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign emit     = busy && out_free;
  assign need_cmd = !busy || (emit && is_last);
  assign q_pop    = need_cmd && q_nonempty;

  // Sequencer state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= S_CHAR;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= emit;
      end
      if (emit) begin
        out_item.out_byte     <= cur_byte;
        out_item.last_of_cell <= is_last;
      end
      if (q_pop) begin
        cmd  <= q_head;
        step <= first_step;
        busy <= 1'b1;
      end else if (emit) begin
        if (is_last) begin
          busy <= 1'b0;
        end else begin
          step <= step_after;
        end
      end
    end
  end

`ifndef SYNTHESIS
  // A background escape is only ever sent for a command that asked for it.
  assert property (@(posedge clk) disable iff (rst)
    busy && (step == S_BG_ESC) |-> cmd.bg_en)
    else $error("background escape without a color change");

  // The reset sequence is only sent for a cell that ends a line.
  assert property (@(posedge clk) disable iff (rst)
    busy && (step == S_RS_ESC) |-> cmd.line_end)
    else $error("reset sequence without a line end");

  // A byte leaves the sequencer only while a command is loaded.
  assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(busy) |-> !$rose(out_valid))
    else $error("output byte without a command");
`endif

endmodule

FILE: src/text_mode_to_ansi_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-mode to ANSI encoder
// Turns text-mode cells into an ANSI text stream with SGR color escapes.
// ----------------------------------------------------------------------------
// The block takes one cell per item and produces one output byte per cycle
// while not stalled. A cell whose colors match the previous cell's on its line
// gives one byte (just the character); each changed color adds five bytes, and
// a line end adds five more, so one cell is 1 to 16 bytes of the back end's
// byte sequencer, which sets the throughput. The front end accepts a cell in
// every cycle while the two-entry queue has room, so cells keep arriving while
// earlier ones are still being written out. line_width may be written only
// while the block is idle; a value of zero makes a line 256 cells long.
module text_mode_to_ansi_encoder_unit
  import tmae_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_nonempty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  assign in_stall = q_full;

  // Front end: classify cells.
  tmae_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // Command queue.
  tmae_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (head_cmd)
  );

  // Back end: emit bytes.
  tmae_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (head_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
